/* hdl/b2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_pkg: shared constants for the binary to decimal digit splitter
// digit width, default value width and the decimal digit count of a width
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int DIGIT_W            = 4;
    localparam int DEFAULT_VALUE_BITS = 31;

    // shift-and-add-3 correction
    localparam logic [DIGIT_W-1:0] ADD_THRESHOLD = 4'd5;
    localparam logic [DIGIT_W-1:0] ADD_AMOUNT    = 4'd3;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT     = 4'd9;

    // decimal digits needed for the largest value of a given bit width
    // floor(bits * log10(2)) + 1, exact over the supported range
    function automatic int digits_for_bits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

endpackage
`default_nettype wire

/* hdl/binary_to_decimal_digits.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_digits: unsigned binary to decimal digit stream
// converts one value with a shift-and-add-3 loop, then sends its digits
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The value is
// converted by one add-3 correction unit working on the whole digit register,
// one binary bit per cycle. The digit register is then shifted out one digit
// per cycle, most significant first: leading zero digits are dropped without
// a strobe, every other digit is put on o_digit for exactly one cycle with
// o_valid high. o_last_digit marks the least significant digit, which always
// ends the request; a zero input gives the single digit 0. All NUM_DIGITS
// positions (10 at the default width) are stepped through, dropped ones
// included, and busy stays high through the conversion and the digit phase.
// The receiver cannot stall: each digit is accepted in the cycle it appears.
// The last digit appears in the cycle in which busy drops, so a new request
// may be made while it is still on the outputs.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits #(
    parameter int VALUE_BITS = b2d_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [VALUE_BITS-1:0]       i_value,
    output logic                             o_valid,
    output logic [b2d_pkg::DIGIT_W-1:0]      o_digit,
    output logic                             o_last_digit
);
    import b2d_pkg::*;

    localparam int NUM_DIGITS = digits_for_bits(VALUE_BITS);
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_BITS - 1);
    localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_BITS-1:0]  r_bin;      // binary bits still to shift in
    logic [BCD_W-1:0]       r_bcd;      // packed decimal digits
    logic [BIT_CNT_W-1:0]   r_bit_cnt;  // conversion step
    logic [DIG_CNT_W-1:0]   r_dig_cnt;  // digit position being sent
    logic                   r_seen;     // a digit has gone out

    logic [BCD_W-1:0]       n_bcd_adj;  // after add-3 correction
    logic [DIGIT_W-1:0]     top_digit;
    logic                   is_last_pos;
    logic                   send_digit;

    // shared correction unit: add 3 to every digit of 5 or more
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= ADD_THRESHOLD) begin
                n_bcd_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + ADD_AMOUNT;
            end else begin
                n_bcd_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit   = r_bcd[BCD_W-1 -: DIGIT_W];
    assign is_last_pos = (r_dig_cnt == LAST_DIGIT);
    // drop leading zeros, but the units digit always goes out
    assign send_digit  = (top_digit != '0) || r_seen || is_last_pos;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            o_valid      <= 1'b0;
            o_last_digit <= 1'b0;
            r_seen       <= 1'b0;
            r_bit_cnt    <= '0;
            r_dig_cnt    <= '0;
        end else begin
            o_valid      <= 1'b0;
            o_last_digit <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_bin     <= i_value;
                        r_bcd     <= '0;
                        r_bit_cnt <= '0;
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    // correct, then shift the next binary bit into the digits
                    r_bcd     <= {n_bcd_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                    r_bin     <= r_bin << 1;
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == LAST_BIT) begin
                        r_dig_cnt <= '0;
                        r_seen    <= 1'b0;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_valid      <= send_digit;
                    o_last_digit <= is_last_pos;
                    o_digit      <= top_digit;
                    if (send_digit) begin
                        r_seen <= 1'b1;
                    end
                    r_bcd     <= r_bcd << DIGIT_W;
                    r_dig_cnt <= r_dig_cnt + 1'b1;
                    if (is_last_pos) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a digit only follows a cycle spent sending digits
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("digit strobe outside digit phase");

    // the units digit always goes out with its flag
    a_last_is_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_digit |-> o_valid)
        else $error("last flag without a digit");

    // digits are decimal
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit <= MAX_DIGIT))
        else $error("digit above nine");

    // a taken request keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // the last digit ends the request
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_digit) |-> !busy)
        else $error("still busy after last digit");

endmodule
`default_nettype wire
